// ===== src/lru_page_replacement_macros.svh =====
// ----------------------------------------------------------------------------
// LRU page replacement assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// same-cycle implication, disabled in reset
`define LRUPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrupr: same-cycle check failed");

// next-cycle implication, disabled in reset
`define LRUPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrupr: next-cycle check failed");

`endif

// ===== src/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement package
// Defaults, state encoding and inter-module control types.
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int FRAMES     = 32;
  localparam int PAGE_BITS  = 10;
  localparam int COUNT_BITS = 16;

  // frames_in_use register
  localparam int          CFG_W        = 6;
  localparam logic [5:0]  FRAMES_RESET = 6'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD
  } lrupr_state_e;

  // priority flags rippled along the cell row
  typedef struct packed {
    logic hit;
    logic empty;
    logic victim;
  } lrupr_found_t;

  // update command broadcast to all cells
  typedef struct packed {
    logic en;
    logic hit;
    logic fill;
  } lrupr_upd_t;

endpackage

// ===== src/lrupr_cell.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement frame cell
// One frame: page, valid flag and recency rank, with its link in the
// lowest-index-first priority chain.
// ----------------------------------------------------------------------------
module lrupr_cell #(
  parameter int FRAMES    = lrupr_pkg::FRAMES,
  parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS,
  parameter int INDEX     = 0,
  parameter int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   active_i,
  input  logic [PAGE_BITS-1:0]   page_i,
  input  logic                   victim_cand_i,
  input  lrupr_pkg::lrupr_found_t found_i,
  output lrupr_pkg::lrupr_found_t found_o,
  input  logic [IDX_W-1:0]       hit_idx_i,
  output logic [IDX_W-1:0]       hit_idx_o,
  input  logic [IDX_W-1:0]       hit_rank_i,
  output logic [IDX_W-1:0]       hit_rank_o,
  input  logic [IDX_W-1:0]       empty_idx_i,
  output logic [IDX_W-1:0]       empty_idx_o,
  input  logic [IDX_W-1:0]       vic_idx_i,
  output logic [IDX_W-1:0]       vic_idx_o,
  input  logic [IDX_W-1:0]       vic_rank_i,
  output logic [IDX_W-1:0]       vic_rank_o,
  input  logic [PAGE_BITS-1:0]   vic_page_i,
  output logic [PAGE_BITS-1:0]   vic_page_o,
  output logic                   valid_o,
  output logic [IDX_W-1:0]       rank_o,
  input  lrupr_pkg::lrupr_upd_t  upd_i,
  input  logic [IDX_W-1:0]       upd_idx_i,
  input  logic [IDX_W-1:0]       limit_i
);

  localparam logic [IDX_W-1:0] CellIdx = IDX_W'(INDEX);
  localparam logic [IDX_W-1:0] RankMax = IDX_W'(FRAMES - 1);

  logic [PAGE_BITS-1:0] page_q, page_d;
  logic                 valid_q, valid_d;
  logic [IDX_W-1:0]     rank_q, rank_d;
  logic                 take_hit, take_empty, take_vic;

  assign take_hit   = active_i && valid_q && (page_q == page_i) && !found_i.hit;
  assign take_empty = active_i && !valid_q && !found_i.empty;
  assign take_vic   = victim_cand_i && !found_i.victim;

  assign found_o.hit    = found_i.hit    | take_hit;
  assign found_o.empty  = found_i.empty  | take_empty;
  assign found_o.victim = found_i.victim | take_vic;

  assign hit_idx_o   = take_hit   ? CellIdx : hit_idx_i;
  assign hit_rank_o  = take_hit   ? rank_q  : hit_rank_i;
  assign empty_idx_o = take_empty ? CellIdx : empty_idx_i;
  assign vic_idx_o   = take_vic   ? CellIdx : vic_idx_i;
  assign vic_rank_o  = take_vic   ? rank_q  : vic_rank_i;
  assign vic_page_o  = take_vic   ? page_q  : vic_page_i;

  assign valid_o = valid_q;
  assign rank_o  = rank_q;

  always_comb begin
    page_d  = page_q;
    valid_d = valid_q;
    rank_d  = rank_q;
    if (upd_i.en && active_i) begin
      if (upd_idx_i == CellIdx) begin
        valid_d = 1'b1;
        rank_d  = '0;
        if (!upd_i.hit) begin
          page_d = page_i;
        end
      end else if (valid_q && (upd_i.fill || (rank_q < limit_i)) && (rank_q != RankMax)) begin
        rank_d = rank_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  // page is only looked at behind the valid flag
  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

endmodule

// ===== src/lrupr_oldest.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement oldest-rank filter
// Narrows the eligible frames to those holding the largest rank, one rank
// bit at a time from the top.
// ----------------------------------------------------------------------------
module lrupr_oldest #(
  parameter int FRAMES = lrupr_pkg::FRAMES,
  parameter int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic [FRAMES-1:0]            elig_i,
  input  logic [FRAMES-1:0][IDX_W-1:0] rank_i,
  output logic [FRAMES-1:0]            cand_o
);

  logic [FRAMES-1:0] cand;
  logic [FRAMES-1:0] col;

  always_comb begin
    cand = elig_i;
    col  = '0;
    for (int b = IDX_W - 1; b >= 0; b--) begin
      for (int i = 0; i < FRAMES; i++) begin
        col[i] = rank_i[i][b];
      end
      if (|(cand & col)) begin
        cand = cand & col;
      end
    end
    cand_o = cand;
  end

endmodule

// ===== src/lru_page_replacement.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement
// Fully associative LRU page-frame policy built as a row of frame cells.
//
//   channel  direction  handshake                  payload
//   cfg      in         cfg_valid_i / cfg_ready_o  frames_in_use_i
//   in       in         in_valid_i / in_ready_o    page_number_i
//   out      out        out_valid_o / out_ready_i  hit, frame, eviction, counts
//
// Each item passes through a lookup cycle, where the priority chain ripples
// through the cell row and the decision is registered, then an update cycle
// in which every cell ages or loads and the result enters the output register.
// The next page transfers in during the update cycle.
// Reset empties all frames, clears counters and sets frames_in_use to 4.
// A result waiting at the output holds the update cycle until it is taken.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
  parameter int FRAMES     = lrupr_pkg::FRAMES,
  parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS,
  parameter int COUNT_BITS = lrupr_pkg::COUNT_BITS,
  parameter int IDX_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lrupr_pkg::CFG_W-1:0]  frames_in_use_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [PAGE_BITS-1:0]         page_number_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         hit_o,
  output logic [IDX_W-1:0]             frame_index_o,
  output logic                         evicted_valid_o,
  output logic [PAGE_BITS-1:0]         evicted_page_o,
  output logic [COUNT_BITS-1:0]        access_count_o,
  output logic [COUNT_BITS-1:0]        fault_count_o
);

  localparam int CntW = $clog2(FRAMES + 1);
  localparam int NW   = (CntW > lrupr_pkg::CFG_W) ? CntW : lrupr_pkg::CFG_W;
  localparam logic [NW-1:0] NMax = NW'(FRAMES);

  lrupr_pkg::lrupr_state_e state_q, state_d;

  logic [lrupr_pkg::CFG_W-1:0] nfr_q;
  logic [NW-1:0]               n_ext, n_eff;
  logic [FRAMES-1:0]           active;
  logic [PAGE_BITS-1:0]        page_q;

  logic in_xfer, out_free, commit, look;

  // chain wires, element i feeds cell i
  lrupr_pkg::lrupr_found_t found_c [FRAMES+1];
  logic [IDX_W-1:0]       hit_idx_c   [FRAMES+1];
  logic [IDX_W-1:0]       hit_rank_c  [FRAMES+1];
  logic [IDX_W-1:0]       empty_idx_c [FRAMES+1];
  logic [IDX_W-1:0]       vic_idx_c   [FRAMES+1];
  logic [IDX_W-1:0]       vic_rank_c  [FRAMES+1];
  logic [PAGE_BITS-1:0]   vic_page_c  [FRAMES+1];

  logic [FRAMES-1:0]            valid_v;
  logic [FRAMES-1:0][IDX_W-1:0] rank_v;
  logic [FRAMES-1:0]            cand;

  // registered decision
  logic                 dec_hit_q, dec_fill_q, dec_evict_q;
  logic [IDX_W-1:0]     dec_idx_q, dec_limit_q;
  logic [PAGE_BITS-1:0] dec_old_q;

  lrupr_pkg::lrupr_upd_t upd;

  logic [COUNT_BITS-1:0] acc_q, flt_q, acc_inc, flt_inc;

  logic                  out_valid_q, out_valid_d;
  logic                  hit_q, evict_q;
  logic [IDX_W-1:0]      fidx_q;
  logic [PAGE_BITS-1:0]  epage_q;
  logic [COUNT_BITS-1:0] acnt_q, fcnt_q;

  // ---- configuration ----
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nfr_q <= lrupr_pkg::FRAMES_RESET;
    end else if (cfg_valid_i) begin
      nfr_q <= frames_in_use_i;
    end
  end

  assign n_ext = NW'(nfr_q);

  always_comb begin
    if (n_ext == '0) begin
      n_eff = NW'(1);
    end else if (n_ext > NMax) begin
      n_eff = NMax;
    end else begin
      n_eff = n_ext;
    end
  end

  // ---- control ----
  assign out_free = !out_valid_q || out_ready_i;
  assign in_xfer  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrupr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    look       = 1'b0;
    commit     = 1'b0;
    case (state_q)
      lrupr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = lrupr_pkg::ST_LOOK;
        end
      end
      lrupr_pkg::ST_LOOK: begin
        look    = 1'b1;
        state_d = lrupr_pkg::ST_UPD;
      end
      lrupr_pkg::ST_UPD: begin
        if (out_free) begin
          commit     = 1'b1;
          in_ready_o = 1'b1;
          state_d    = in_valid_i ? lrupr_pkg::ST_LOOK : lrupr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lrupr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      page_q <= page_number_i;
    end
  end

  // ---- cell row ----
  assign found_c[0]     = '0;
  assign hit_idx_c[0]   = '0;
  assign hit_rank_c[0]  = '0;
  assign empty_idx_c[0] = '0;
  assign vic_idx_c[0]   = '0;
  assign vic_rank_c[0]  = '0;
  assign vic_page_c[0]  = '0;

  assign upd.en   = commit;
  assign upd.hit  = dec_hit_q;
  assign upd.fill = dec_fill_q;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    assign active[i] = (NW'(i) < n_eff);

    lrupr_cell #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS),
      .INDEX     (i),
      .IDX_W     (IDX_W)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .active_i      (active[i]),
      .page_i        (page_q),
      .victim_cand_i (cand[i]),
      .found_i       (found_c[i]),
      .found_o       (found_c[i+1]),
      .hit_idx_i     (hit_idx_c[i]),
      .hit_idx_o     (hit_idx_c[i+1]),
      .hit_rank_i    (hit_rank_c[i]),
      .hit_rank_o    (hit_rank_c[i+1]),
      .empty_idx_i   (empty_idx_c[i]),
      .empty_idx_o   (empty_idx_c[i+1]),
      .vic_idx_i     (vic_idx_c[i]),
      .vic_idx_o     (vic_idx_c[i+1]),
      .vic_rank_i    (vic_rank_c[i]),
      .vic_rank_o    (vic_rank_c[i+1]),
      .vic_page_i    (vic_page_c[i]),
      .vic_page_o    (vic_page_c[i+1]),
      .valid_o       (valid_v[i]),
      .rank_o        (rank_v[i]),
      .upd_i         (upd),
      .upd_idx_i     (dec_idx_q),
      .limit_i       (dec_limit_q)
    );
  end

  lrupr_oldest #(
    .FRAMES (FRAMES),
    .IDX_W  (IDX_W)
  ) u_oldest (
    .elig_i (active & valid_v),
    .rank_i (rank_v),
    .cand_o (cand)
  );

  // ---- decision, registered at the end of the lookup cycle ----
  always_ff @(posedge clk_i) begin
    if (look) begin
      dec_hit_q   <= found_c[FRAMES].hit;
      dec_fill_q  <= 1'b0;
      dec_evict_q <= 1'b0;
      dec_old_q   <= '0;
      if (found_c[FRAMES].hit) begin
        dec_idx_q   <= hit_idx_c[FRAMES];
        dec_limit_q <= hit_rank_c[FRAMES];
      end else if (found_c[FRAMES].empty) begin
        dec_idx_q   <= empty_idx_c[FRAMES];
        dec_limit_q <= '0;
        dec_fill_q  <= 1'b1;
      end else begin
        dec_idx_q   <= vic_idx_c[FRAMES];
        dec_limit_q <= vic_rank_c[FRAMES];
        dec_evict_q <= 1'b1;
        dec_old_q   <= vic_page_c[FRAMES];
      end
    end
  end

  // ---- counters ----
  assign acc_inc = (&acc_q) ? acc_q : acc_q + 1'b1;
  assign flt_inc = (&flt_q) ? flt_q : flt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      flt_q <= '0;
    end else if (commit) begin
      acc_q <= acc_inc;
      if (!dec_hit_q) begin
        flt_q <= flt_inc;
      end
    end
  end

  // ---- output register ----
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      hit_q   <= dec_hit_q;
      fidx_q  <= dec_idx_q;
      evict_q <= dec_evict_q;
      epage_q <= dec_old_q;
      acnt_q  <= acc_inc;
      fcnt_q  <= dec_hit_q ? flt_q : flt_inc;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign frame_index_o   = fidx_q;
  assign evicted_valid_o = evict_q;
  assign evicted_page_o  = epage_q;
  assign access_count_o  = acnt_q;
  assign fault_count_o   = fcnt_q;

endmodule

// ===== src/lrupr_checker.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "lru_page_replacement_macros.svh"

module lrupr_checker #(
  parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS,
  parameter int COUNT_BITS = lrupr_pkg::COUNT_BITS,
  parameter int IDX_W      = 5
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic                  hit_o,
  input logic [IDX_W-1:0]      frame_index_o,
  input logic                  evicted_valid_o,
  input logic [PAGE_BITS-1:0]  evicted_page_o,
  input logic [COUNT_BITS-1:0] access_count_o,
  input logic [COUNT_BITS-1:0] fault_count_o
);

  // a stalled result keeps its frame and access count
  `LRUPR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(frame_index_o) && $stable(access_count_o))

  // an eviction only ever comes with a fault
  `LRUPR_ASSERT_NOW(a_evict_fault, clk_i, rst_ni, out_valid_o && evicted_valid_o, !hit_o)

  // evicted page reads zero when nothing was replaced
  `LRUPR_ASSERT_NOW(a_evict_zero, clk_i, rst_ni, out_valid_o && !evicted_valid_o, evicted_page_o == '0)

  // faults never outnumber accesses, and every result counts at least one access
  `LRUPR_ASSERT_NOW(a_count_order, clk_i, rst_ni, out_valid_o, (fault_count_o <= access_count_o) && (access_count_o != '0))

endmodule

bind lru_page_replacement lrupr_checker #(
  .PAGE_BITS  (PAGE_BITS),
  .COUNT_BITS (COUNT_BITS),
  .IDX_W      (IDX_W)
) u_lrupr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .hit_o           (hit_o),
  .frame_index_o   (frame_index_o),
  .evicted_valid_o (evicted_valid_o),
  .evicted_page_o  (evicted_page_o),
  .access_count_o  (access_count_o),
  .fault_count_o   (fault_count_o)
);

// ===== tb/tb_lru_page_replacement.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU page replacement testbench
// Drives page accesses and frame-count writes through the valid/ready ports,
// predicts every result with a behavioural LRU frame table, and checks each
// output transfer field by field. Covers reset defaults, frame-count limits,
// stale frames, random working sets and back-pressure.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement;

  localparam int NF         = lrupr_pkg::FRAMES;
  localparam int PAGE_W     = lrupr_pkg::PAGE_BITS;
  localparam int CNT_W      = lrupr_pkg::COUNT_BITS;
  localparam int IDX_W      = $clog2(NF);
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RX_HOLD    = 80;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  frame;
    logic              ev_valid;
    logic [PAGE_W-1:0] ev_page;
    logic [CNT_W-1:0]  accesses;
    logic [CNT_W-1:0]  faults;
  } access_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [lrupr_pkg::CFG_W-1:0] frames_in_use_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [PAGE_W-1:0] page_number_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              hit_o;
  logic [IDX_W-1:0]  frame_index_o;
  logic              evicted_valid_o;
  logic [PAGE_W-1:0] evicted_page_o;
  logic [CNT_W-1:0]  access_count_o;
  logic [CNT_W-1:0]  fault_count_o;

  // behavioural frame table
  logic [PAGE_W-1:0] frame_pages[NF];
  bit                frame_used[NF];
  int unsigned       frame_age[NF];
  logic [CNT_W-1:0]  access_total;
  logic [CNT_W-1:0]  fault_total;
  logic [lrupr_pkg::CFG_W-1:0] frames_setting;

  access_result_t pending_results[$];

  int unsigned cycles;
  int unsigned errors;
  int unsigned pages_sent;
  int unsigned results_seen;
  int unsigned cfg_writes;
  logic [CNT_W-1:0] last_accesses;
  logic [CNT_W-1:0] last_faults;
  bit idle_en;
  bit hold_rx_req;

  lru_page_replacement u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .frames_in_use_i (frames_in_use_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .page_number_i   (page_number_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .frame_index_o   (frame_index_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .access_count_o  (access_count_o),
    .fault_count_o   (fault_count_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("lru_page_replacement: mismatch");
      $finish;
    end
  end

  // One access through the frame table; updates the table and the counters.
  function automatic access_result_t lru_access(input logic [PAGE_W-1:0] page);
    access_result_t r;
    int n;
    int f;
    int i;
    bit is_hit;
    bit has_empty;
    int unsigned age_limit;
    r = '0;
    n = int'(frames_setting);
    if (n < 1) n = 1;
    if (n > NF) n = NF;
    is_hit = 1'b0;
    has_empty = 1'b0;
    f = 0;
    for (i = 0; i < n; i++)
      if (!is_hit && frame_used[i] && frame_pages[i] == page) begin
        is_hit = 1'b1;
        f = i;
      end
    if (access_total != '1) access_total++;
    if (is_hit) begin
      age_limit = frame_age[f];
    end else begin
      if (fault_total != '1) fault_total++;
      for (i = 0; i < n; i++)
        if (!has_empty && !frame_used[i]) begin
          has_empty = 1'b1;
          f = i;
        end
      if (has_empty) begin
        age_limit = NF;  // fill: every valid frame ages
      end else begin
        f = 0;
        for (i = 1; i < n; i++)
          if (frame_age[i] > frame_age[f]) f = i;
        r.ev_valid = 1'b1;
        r.ev_page = frame_pages[f];
        age_limit = frame_age[f];
      end
    end
    for (i = 0; i < n; i++)
      if (i != f && frame_used[i] && frame_age[i] < age_limit && frame_age[i] < NF - 1)
        frame_age[i]++;
    frame_age[f] = 0;
    if (!is_hit) begin
      frame_pages[f] = page;
      frame_used[f] = 1'b1;
    end
    r.hit = is_hit;
    r.frame = IDX_W'(f);
    r.accesses = access_total;
    r.faults = fault_total;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                results_seen, name, got, want));
  endtask

  // result checker
  always @(posedge clk_i) begin
    access_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      last_accesses = access_count_o;
      last_faults = fault_count_o;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d with no access outstanding", results_seen));
      end else begin
        want = pending_results.pop_front();
        check_field("hit", hit_o, want.hit);
        check_field("frame_index", frame_index_o, want.frame);
        check_field("evicted_valid", evicted_valid_o, want.ev_valid);
        check_field("evicted_page", evicted_page_o, want.ev_page);
        check_field("access_count", access_count_o, want.accesses);
        check_field("fault_count", fault_count_o, want.faults);
      end
    end
  end

  // result-side ready: random stall bursts, or one long hold on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rx_req) begin
        out_ready_i <= 1'b0;
        repeat (RX_HOLD - 1) @(negedge clk_i);
        hold_rx_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Returns at the edge of the transfer, with valid still high.
  task automatic send_page(input logic [PAGE_W-1:0] page);
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    page_number_i <= page;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(lru_access(page));
    pages_sent++;
  endtask

  // drop valid, then wait for every outstanding result plus a little slack
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_frames(input logic [lrupr_pkg::CFG_W-1:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    frames_in_use_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    frames_setting = value;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [PAGE_W-1:0] pick_page(input logic [PAGE_W-1:0] base,
                                                  input int unsigned pool);
    if ($urandom_range(0, 7) == 0) return PAGE_W'($urandom_range(0, (1 << PAGE_W) - 1));
    return base + PAGE_W'($urandom_range(0, pool - 1));
  endfunction

  task automatic test_reset_defaults();
    // four frames after reset: fill, hit, then evict the oldest
    send_page(10'h000);
    send_page(10'h3FF);
    send_page(10'h155);
    send_page(10'h2AA);
    send_page(10'h000);
    send_page(10'h007);
    send_page(10'h2AA);
    wait_idle();
  endtask

  task automatic test_frame_count_limits();
    set_frames(6'd0);   // acts as one frame
    send_page(10'h005);
    send_page(10'h005);
    send_page(10'h006);
    set_frames(6'd63);  // clamps to the full row
    send_page(10'h3FF);
    send_page(10'h155);
    set_frames(6'd32);
    send_page(10'h200);
    wait_idle();
  endtask

  task automatic test_stale_frames();
    set_frames(6'd4);
    send_page(10'h100);
    send_page(10'h101);
    send_page(10'h102);
    send_page(10'h103);
    // shrink: frames 2 and 3 go stale with their ranks
    set_frames(6'd2);
    send_page(10'h104);
    send_page(10'h103);
    // grow back: duplicate page, shared top rank
    set_frames(6'd4);
    send_page(10'h103);
    send_page(10'h107);
    wait_idle();
  endtask

  task automatic test_random_working_sets();
    logic [lrupr_pkg::CFG_W-1:0] settings[8];
    logic [PAGE_W-1:0] base;
    int unsigned pool;
    int n;
    settings = '{6'd1, 6'd32, 6'd63, 6'd0, 6'd3, 6'd8, 6'd16, 6'd0};
    settings[7] = lrupr_pkg::CFG_W'($urandom_range(0, 63));
    for (int ph = 0; ph < 8; ph++) begin
      idle_en = (ph < 6) && (ph != 2);
      set_frames(settings[ph]);
      n = int'(settings[ph]);
      if (n < 1) n = 1;
      if (n > NF) n = NF;
      pool = n + n / 2 + 1;
      base = PAGE_W'($urandom_range(0, (1 << PAGE_W) - 1));
      for (int k = 0; k < 175; k++) begin
        if (k % 60 == 59) base = PAGE_W'($urandom_range(0, (1 << PAGE_W) - 1));
        send_page(pick_page(base, pool));
      end
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    logic [PAGE_W-1:0] base;
    idle_en = 1'b0;
    set_frames(6'd4);
    base = PAGE_W'($urandom_range(0, (1 << PAGE_W) - 1));
    hold_rx_req = 1'b1;
    for (int k = 0; k < 12; k++) send_page(pick_page(base, 6));
    wait_idle();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    frames_in_use_i = '0;
    in_valid_i = 1'b0;
    page_number_i = '0;
    out_ready_i = 1'b0;
    idle_en = 1'b1;
    hold_rx_req = 1'b0;
    for (int i = 0; i < NF; i++) begin
      frame_pages[i] = '0;
      frame_used[i] = 1'b0;
      frame_age[i] = 0;
    end
    access_total = '0;
    fault_total = '0;
    frames_setting = lrupr_pkg::FRAMES_RESET;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    test_frame_count_limits();
    test_stale_frames();
    test_random_working_sets();
    test_backpressure();

    repeat (8) @(negedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("covered %0d page accesses, %0d results checked, %0d frame-count writes",
             pages_sent, results_seen, cfg_writes);
    $display("final counters: accesses %0d, faults %0d", last_accesses, last_faults);
    if (errors == 0) begin
      $display("lru_page_replacement: match");
    end else begin
      $display("lru_page_replacement: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/lrupr_pkg.sv
src/lrupr_cell.sv
src/lrupr_oldest.sv
src/lru_page_replacement.sv
src/lrupr_checker.sv
tb/tb_lru_page_replacement.sv
